>>> hw/rtl/wrnu_pkg.sv
// Package for the windowed ratio map normalizer.
// Holds command codes, register indexes, fixed widths and the sequencer state type.
// No dependencies.
`default_nettype none

package wrnu_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_SCALE   = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_REFERENCE = 2'd0;
    localparam logic [1:0] REG_MAPS      = 2'd1;
    localparam logic [1:0] REG_FEATURES  = 2'd2;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] RATIO_LIM = 17'd98304;
    localparam int unsigned QBITS     = 17;

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_FA     = 9'b000000100,
        S_FB     = 9'b000001000,
        S_FC     = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_MAPEND = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_SMUL   = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/wrnu_in_if.sv
// Input channel interface of the windowed ratio map normalizer.
// Depends on wrnu_pkg for the command type.
`default_nettype none

interface wrnu_in_if
    import wrnu_pkg::*;
();
    logic        valid;
    logic        ready;
    t_cmd        command;
    logic [2:0]  map_index;
    logic [9:0]  feature_index;
    logic [31:0] intensity;

    modport source (output valid, output command, output map_index,
                    output feature_index, output intensity, input ready);
    modport sink   (input valid, input command, input map_index,
                    input feature_index, input intensity, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wrnu_out_if.sv
// Result channel interface of the windowed ratio map normalizer.
// No dependencies.
`default_nettype none

interface wrnu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_map;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output out_map, output value, output last,
                    input ready);
    modport sink   (input valid, input out_map, input value, input last,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wrnu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wrnu_ram #(
    parameter int unsigned W     = 32,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

>>> hw/rtl/windowed_ratio_map_normalizer_unit.sv
// Top level of the windowed ratio map normalizer: store, sequencer, shared divider.
// Depends on wrnu_pkg, wrnu_in_if, wrnu_out_if and wrnu_ram.
//
// channel   dir   fields                                          handshake
// i_in      in    command, map_index, feature_index, intensity    valid/ready
// o_out     out   out_map, value, last                            valid/ready
// apb       in    paddr, pwdata -> prdata                         psel/penable, pready=1
//
// Load writes the store in the accept cycle; scale passes through S_SMUL and S_EMIT.
// Compute: per map, states S_FA, S_FB, S_FC per feature row, the divider per kept
// ratio and the mean, paced by the single RAM read port and 17-step shared divider.
// Reset and clear run a clearing pass over MAX_MAPS*MAX_FEATURES words (rounded up
// to powers of two per dimension); config writes are taken meanwhile.
// A full output register stalls the sequencer at each result.
`default_nettype none

module windowed_ratio_map_normalizer_unit
    import wrnu_pkg::*;
#(
    parameter int unsigned MAX_MAPS     = 8,
    parameter int unsigned MAX_FEATURES = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    wrnu_in_if.sink                 i_in,
    wrnu_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    localparam int unsigned MW  = $clog2(MAX_MAPS);
    localparam int unsigned FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int unsigned AW  = MW + FW;
    localparam int unsigned NR  = (MAX_MAPS < 8) ? MAX_MAPS : 8;
    localparam int unsigned RIW = $clog2(NR);
    localparam int unsigned SW  = QBITS + FW + 1;

    logic [2:0]  r_cfg_ref;
    logic [3:0]  r_cfg_maps;
    logic [10:0] r_cfg_feat;

    t_state      r_st;
    logic [AW-1:0] r_clr;
    logic [MW-1:0] r_rm;
    logic [3:0]  r_m;
    logic [3:0]  r_nm;
    logic [FW:0] r_f;
    logic [FW:0] r_nf;
    logic [31:0] r_a;
    logic [SW-1:0] r_sum;
    logic [FW:0] r_cnt;
    logic [32:0] r_rem;
    logic [16:0] r_low;
    logic [32:0] r_div;
    logic [16:0] r_q;
    logic [4:0]  r_dc;
    logic        r_mean;
    logic        r_scale;
    logic [31:0] r_res;
    logic [2:0]  r_smap;
    logic [31:0] r_x;
    logic [16:0] r_rat;
    logic [16:0] r_ratio [NR];

    logic        r_ovalid;
    logic [2:0]  r_omap;
    logic [31:0] r_oval;
    logic        r_olast;

    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0] ram_rdata;

    logic        in_acc;
    logic        out_free;
    logic        emit_go;
    logic        load_ok;
    logic [32:0] n_t;
    logic        n_ge;
    logic        n_keep;
    logic [48:0] n_prod;
    logic        n_last;

    assign pready = 1'b1;
    assign i_in.ready = (r_st == S_IDLE);
    assign in_acc = i_in.valid && (r_st == S_IDLE);
    assign out_free = !r_ovalid || o_out.ready;
    assign emit_go = (r_st == S_EMIT) && out_free;
    assign o_out.valid = r_ovalid;
    assign o_out.out_map = r_omap;
    assign o_out.value = r_oval;
    assign o_out.last = r_olast;

    always_comb begin
        case (paddr[3:2])
            REG_REFERENCE: prdata = {29'd0, r_cfg_ref};
            REG_MAPS:      prdata = {28'd0, r_cfg_maps};
            REG_FEATURES:  prdata = {21'd0, r_cfg_feat};
            default:       prdata = 32'd0;
        endcase
    end

    assign load_ok = (32'(i_in.map_index) < MAX_MAPS) &&
                     (32'(i_in.feature_index) < MAX_FEATURES);
    assign ram_we = (r_st == S_CLR) || (in_acc && i_in.command == CMD_LOAD && load_ok);
    assign ram_waddr = (r_st == S_CLR) ? r_clr :
                       {MW'(i_in.map_index), FW'(i_in.feature_index)};
    assign ram_wdata = (r_st == S_CLR) ? 32'd0 : i_in.intensity;
    assign ram_raddr = (r_st == S_FA) ? {r_rm, r_f[FW-1:0]} : {MW'(r_m), r_f[FW-1:0]};

    assign n_t  = {r_rem[31:0], r_low[16]};
    assign n_ge = (n_t >= r_div);
    assign n_keep = (r_a != 32'd0) && (ram_rdata != 32'd0) &&
                    ((39'd100 * 39'(r_a)) > (39'd67 * 39'(ram_rdata))) &&
                    ((34'd2 * 34'(r_a)) < (34'd3 * 34'(ram_rdata)));
    assign n_prod = 49'(r_x) * 49'(r_rat);
    assign n_last = ((r_m + 4'd1) == r_nm);

    wrnu_ram #(.W(32), .DEPTH(2 ** AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ref  <= 3'd0;
            r_cfg_maps <= 4'd8;
            r_cfg_feat <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_REFERENCE: r_cfg_ref  <= pwdata[2:0];
                REG_MAPS:      r_cfg_maps <= pwdata[3:0];
                REG_FEATURES:  r_cfg_feat <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NR; i++) begin
                r_ratio[i] <= ONE_Q16;
            end
        end else begin
            if (r_ovalid && o_out.ready && !emit_go) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {AW{1'b1}}) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.command)
                            CMD_CLEAR: begin
                                r_clr <= '0;
                                r_st  <= S_CLR;
                            end
                            CMD_SCALE: begin
                                r_x     <= i_in.intensity;
                                r_smap  <= i_in.map_index;
                                r_scale <= 1'b1;
                                if (32'(i_in.map_index) < NR) begin
                                    r_rat <= r_ratio[i_in.map_index[RIW-1:0]];
                                end else begin
                                    r_rat <= ONE_Q16;
                                end
                                r_st <= S_SMUL;
                            end
                            CMD_COMPUTE: begin
                                r_scale <= 1'b0;
                                if (r_cfg_maps == 4'd0) begin
                                    r_nm <= 4'd1;
                                end else if (32'(r_cfg_maps) > NR) begin
                                    r_nm <= 4'(NR);
                                end else begin
                                    r_nm <= r_cfg_maps;
                                end
                                if (32'(r_cfg_feat) > MAX_FEATURES) begin
                                    r_nf <= (FW+1)'(MAX_FEATURES);
                                end else begin
                                    r_nf <= (FW+1)'(r_cfg_feat);
                                end
                                if (32'(r_cfg_ref) >= MAX_MAPS) begin
                                    r_rm <= MW'(MAX_MAPS - 1);
                                end else begin
                                    r_rm <= MW'(r_cfg_ref);
                                end
                                r_m   <= 4'd0;
                                r_f   <= '0;
                                r_sum <= '0;
                                r_cnt <= '0;
                                r_st  <= S_FA;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FA: begin
                    if (r_f == r_nf) begin
                        r_st <= S_MAPEND;
                    end else begin
                        r_st <= S_FB;
                    end
                end
                S_FB: begin
                    r_a  <= ram_rdata;
                    r_st <= S_FC;
                end
                S_FC: begin
                    r_f <= r_f + 1'b1;
                    if (n_keep) begin
                        r_rem  <= {2'd0, r_a[31:1]};
                        r_low  <= {r_a[0], 16'd0};
                        r_div  <= {1'b0, ram_rdata};
                        r_dc   <= 5'd0;
                        r_mean <= 1'b0;
                        r_st   <= S_DIV;
                    end else begin
                        r_st <= S_FA;
                    end
                end
                S_DIV: begin
                    r_rem <= n_ge ? (n_t - r_div) : n_t;
                    r_low <= {r_low[15:0], 1'b0};
                    r_q   <= {r_q[15:0], n_ge};
                    r_dc  <= r_dc + 5'd1;
                    if (r_dc == 5'(QBITS - 1)) begin
                        if (r_mean) begin
                            r_res <= {15'd0, r_q[15:0], n_ge};
                            r_st  <= S_EMIT;
                        end else begin
                            r_sum <= r_sum + SW'({r_q[15:0], n_ge});
                            r_cnt <= r_cnt + 1'b1;
                            r_st  <= S_FA;
                        end
                    end
                end
                S_MAPEND: begin
                    if (r_cnt == '0) begin
                        r_res <= {15'd0, ONE_Q16};
                        r_st  <= S_EMIT;
                    end else begin
                        r_rem  <= 33'(r_sum >> QBITS);
                        r_low  <= r_sum[16:0];
                        r_div  <= 33'(r_cnt);
                        r_dc   <= 5'd0;
                        r_mean <= 1'b1;
                        r_st   <= S_DIV;
                    end
                end
                S_SMUL: begin
                    if (n_prod[48:48] != 1'b0) begin
                        r_res <= 32'hFFFF_FFFF;
                    end else begin
                        r_res <= n_prod[47:16];
                    end
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_res;
                        if (r_scale) begin
                            r_omap  <= r_smap;
                            r_olast <= 1'b1;
                            r_st    <= S_IDLE;
                        end else begin
                            r_omap  <= r_m[2:0];
                            r_olast <= n_last;
                            r_ratio[r_m[RIW-1:0]] <= r_res[16:0];
                            if (n_last) begin
                                r_st <= S_IDLE;
                            end else begin
                                r_m   <= r_m + 4'd1;
                                r_f   <= '0;
                                r_sum <= '0;
                                r_cnt <= '0;
                                r_st  <= S_FA;
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_clear_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.command == CMD_CLEAR) |=> (r_st == S_CLR))
        else $error("clear beat did not start clearing pass");
    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_EMIT && !r_scale) |-> (r_res < 32'(RATIO_LIM)))
        else $error("mean ratio out of range");
    a_map_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FA) |-> (r_m < r_nm && r_f <= r_nf))
        else $error("compute walk counters out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> $stable(r_oval))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
